// ===== hw/rtl/programmable_interrupt_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the programmable interrupt controller
// Clocked, reset-qualified property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PROGRAMMABLE_INTERRUPT_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PIC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pic assertion failed");

// next-cycle implication
`define PIC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pic assertion failed");

`endif

// ===== hw/rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Types and constants shared by the interrupt controller files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RAISE = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	typedef logic [1:0] op_bits_t;
	typedef logic [7:0] byte_t;
	typedef logic [2:0] line_t;
	typedef logic [2:0] step_t;

	typedef struct packed {
		logic  found;
		line_t idx;
	} grant_t;

	localparam logic  PORT_CMD  = 1'b0;
	localparam logic  PORT_DATA = 1'b1;

	localparam int    ICW1_BIT     = 4;
	localparam int    EOI_BIT      = 5;
	localparam int    OCW3_RD_BIT  = 1;
	localparam int    OCW3_SEL_BIT = 0;
	localparam int    SNGL_BIT     = 1;
	localparam int    AEOI_BIT     = 1;
	localparam byte_t OCW3_MASK    = 8'h98;
	localparam byte_t OCW3_MATCH   = 8'h08;

	localparam step_t STEP_ICW1 = 3'd1;
	localparam step_t STEP_ICW2 = 3'd2;
	localparam step_t STEP_ICW3 = 3'd3;
	localparam step_t STEP_ICW4 = 3'd4;
	localparam step_t STEP_DONE = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/pic_if.sv =====
// ----------------------------------------------------------------------------
// pic_req_if / pic_rsp_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pic_req_if;
	logic                valid;
	logic                ready;
	pic_pkg::op_bits_t   op;
	logic                port_sel;
	pic_pkg::byte_t      data;
	pic_pkg::line_t      irq_line;

	modport source (output valid, output op, output port_sel, output data,
		output irq_line, input ready);
	modport sink (input valid, input op, input port_sel, input data,
		input irq_line, output ready);
endinterface

interface pic_rsp_if;
	logic                valid;
	logic                ready;
	pic_pkg::byte_t      read_data;
	pic_pkg::byte_t      vector;
	logic                vector_valid;

	modport source (output valid, output read_data, output vector,
		output vector_valid, input ready);
	modport sink (input valid, input read_data, input vector,
		input vector_valid, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pic_lowest.sv =====
// ----------------------------------------------------------------------------
// pic_lowest
// Fixed-priority encoder: finds the lowest set bit of an eight-bit vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pic_lowest (
	input  pic_pkg::byte_t  bits,
	output pic_pkg::grant_t grant
);
	import pic_pkg::*;

	always_comb begin
		grant = '0;
		for (int i = 7; i >= 0; i--) begin
			if (bits[i]) begin
				grant.found = 1'b1;
				grant.idx   = line_t'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/programmable_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// programmable_interrupt_controller
// Eight-line interrupt controller: port access, requests and acknowledge.
// ----------------------------------------------------------------------------
// Takes one operation beat per cycle while results are taken, and returns
// exactly one result beat per operation, in order. A beat is captured in
// an input register; then logic (two lowest-bit encoders, the register
// update and the vector add) produces the result register and the new
// controller state, so the sustained rate is one beat per cycle; the
// request side keeps moving while a finished result waits on the response
// side, stalling only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module programmable_interrupt_controller (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pic_req_if.sink    req,
	pic_rsp_if.source  rsp
);
	import pic_pkg::*;

	logic   valid_s1;
	op_t    op_s1;
	logic   port_s1;
	byte_t  data_s1;
	line_t  line_s1;
	logic   adv_s1;

	byte_t  mask_q, pend_q, serv_q, icw1_q, base_q, icw4_q;
	step_t  step_q;
	logic   rsel_q;

	byte_t  mask_d, pend_d, serv_d, icw1_d, base_d, icw4_d;
	step_t  step_d, step_eff;
	logic   rsel_d;

	byte_t  rd_d, vec_d;
	logic   vv_d;

	logic   valid_s2;
	byte_t  rd_s2, vec_s2;
	logic   vv_s2;

	byte_t  elig;
	grant_t ack_grant, eoi_grant;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= op_t'(req.op);
			port_s1 <= req.port_sel;
			data_s1 <= req.data;
			line_s1 <= req.irq_line;
		end
	end

	assign elig = pend_q & ~mask_q & ~serv_q;

	pic_lowest u_ack (.bits(elig),   .grant(ack_grant));
	pic_lowest u_eoi (.bits(serv_q), .grant(eoi_grant));

	assign step_eff = (step_q == STEP_ICW3 && icw1_q[SNGL_BIT]) ? STEP_ICW4 : step_q;

	always_comb begin
		mask_d = mask_q;
		pend_d = pend_q;
		serv_d = serv_q;
		icw1_d = icw1_q;
		base_d = base_q;
		icw4_d = icw4_q;
		step_d = step_q;
		rsel_d = rsel_q;
		rd_d   = '0;
		vec_d  = '0;
		vv_d   = 1'b0;
		case (op_s1)
			OP_READ: begin
				if (port_s1 == PORT_DATA) begin
					rd_d = mask_q;
				end else begin
					rd_d = rsel_q ? serv_q : pend_q;
				end
			end
			OP_WRITE: begin
				if (port_s1 == PORT_CMD) begin
					if (data_s1[ICW1_BIT]) begin
						mask_d = '0;
						icw1_d = data_s1;
						step_d = STEP_ICW2;
					end else begin
						if ((data_s1 & OCW3_MASK) == OCW3_MATCH && data_s1[OCW3_RD_BIT]) begin
							rsel_d = data_s1[OCW3_SEL_BIT];
						end
						if (data_s1[EOI_BIT] && eoi_grant.found) begin
							serv_d = serv_q & ~(8'b1 << eoi_grant.idx);
						end
					end
				end else if (step_eff < STEP_DONE) begin
					case (step_eff)
						STEP_ICW1: icw1_d = data_s1;
						STEP_ICW2: base_d = data_s1;
						STEP_ICW4: icw4_d = data_s1;
						default: ;
					endcase
					step_d = step_eff + 3'd1;
				end else begin
					mask_d = data_s1;
				end
			end
			OP_RAISE: begin
				pend_d = pend_q | (8'b1 << line_s1);
			end
			OP_ACK: begin
				if (ack_grant.found) begin
					pend_d = pend_q & ~(8'b1 << ack_grant.idx);
					if (!icw4_q[AEOI_BIT]) begin
						serv_d = serv_q | (8'b1 << ack_grant.idx);
					end
					vec_d = base_q + {5'b0, ack_grant.idx};
					vv_d  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			pend_q <= '0;
			serv_q <= '0;
			icw1_q <= '0;
			base_q <= '0;
			icw4_q <= '0;
			step_q <= '0;
			rsel_q <= 1'b0;
		end else if (adv_s1) begin
			mask_q <= mask_d;
			pend_q <= pend_d;
			serv_q <= serv_d;
			icw1_q <= icw1_d;
			base_q <= base_d;
			icw4_q <= icw4_d;
			step_q <= step_d;
			rsel_q <= rsel_d;
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rd_s2  <= rd_d;
			vec_s2 <= vec_d;
			vv_s2  <= vv_d;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.read_data    = rd_s2;
	assign rsp.vector       = vec_s2;
	assign rsp.vector_valid = vv_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/pic_checker.sv =====
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks on result beats of the interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "programmable_interrupt_controller_assert.svh"

module pic_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [7:0] rsp_read_data,
	input wire logic [7:0] rsp_vector,
	input wire logic rsp_vector_valid
);

	`PIC_ASSERT_SAME(a_vec_zero, rsp_valid && !rsp_vector_valid, rsp_vector == 8'h00)
	`PIC_ASSERT_SAME(a_rd_excl, rsp_valid && rsp_vector_valid, rsp_read_data == 8'h00)
	`PIC_ASSERT_SAME(a_beat_src, $rose(rsp_valid), $past(req_valid && req_ready, 2))
	`PIC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_vector) && $stable(rsp_vector_valid))

endmodule

bind programmable_interrupt_controller pic_checker u_pic_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_read_data    (rsp.read_data),
	.rsp_vector       (rsp.vector),
	.rsp_vector_valid (rsp.vector_valid)
);

`default_nettype wire
